### rtl/fsvn_pkg.sv
// ----------------------------------------------------------------------------
// fsvn_pkg: shared types and constants of the fibre/sheet vector normalizer
// Widths, reset value of the tolerance register and the per-vector bundle.
// ----------------------------------------------------------------------------
package fsvn_pkg;

   localparam int COMP_W       = 24;
   localparam int TOL_W        = 21;
   localparam int FRAC_BITS_DEF = 20;
   localparam logic [TOL_W-1:0] TOL_RESET = 21'd10;
   localparam logic [COMP_W-1:0] COMP_MAXPOS = 24'h7FFFFF;
   localparam logic [COMP_W-1:0] COMP_MAXNEG = 24'h800000;

   // one vector's components as carried through the chain
   typedef struct packed {
      logic [COMP_W-1:0] x;
      logic [COMP_W-1:0] y;
      logic [COMP_W-1:0] z;
   } vec_type;

   // per-vector control travelling with the data
   typedef struct packed {
      logic fix;
      logic zero;
      logic [2:0] neg;
   } vctl_type;

endpackage

### rtl/fibre_sheet_vector_normalizer.sv
// ----------------------------------------------------------------------------
// fibre_sheet_vector_normalizer: top level
// Normalizes the fibre and sheet vectors of each item to unit length.
// ----------------------------------------------------------------------------
// One item enters per clock unless the output is stalled, and passes through
// three front stages (magnitude, squares, sum and tolerance test), one
// cell per root bit of the 50-bit sum (25), one rounding stage, one divider
// cell per quotient bit (COMP_W + FRAC_BITS, 44 by default) and one output
// stage. The whole chain advances together and stalls when the result is not
// taken; the valid shift line tracks occupancy so a new item is accepted
// whenever the output slot is free or being drained.
module fibre_sheet_vector_normalizer
   import fsvn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [TOL_W-1:0]         csr_norm_tolerance,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COMP_W-1:0] req_fibre_x,
   input  logic signed [COMP_W-1:0] req_fibre_y,
   input  logic signed [COMP_W-1:0] req_fibre_z,
   input  logic signed [COMP_W-1:0] req_sheet_x,
   input  logic signed [COMP_W-1:0] req_sheet_y,
   input  logic signed [COMP_W-1:0] req_sheet_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COMP_W-1:0] rsp_fibre_x_out,
   output logic signed [COMP_W-1:0] rsp_fibre_y_out,
   output logic signed [COMP_W-1:0] rsp_fibre_z_out,
   output logic signed [COMP_W-1:0] rsp_sheet_x_out,
   output logic signed [COMP_W-1:0] rsp_sheet_y_out,
   output logic signed [COMP_W-1:0] rsp_sheet_z_out,
   output logic                     rsp_fibre_rescaled,
   output logic                     rsp_sheet_rescaled,
   output logic                     rsp_fibre_is_zero,
   output logic                     rsp_sheet_is_zero
);

   localparam int RW    = (2*COMP_W + 2) / 2;
   localparam int DEPTH = 3 + RW + 1 + (COMP_W + FRAC_BITS) + 1;

   logic [TOL_W-1:0] tol_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             advance;
   vec_type          fib_res, sht_res;

   // hold the tolerance register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_norm_tolerance;
      end
   end

   // advance the whole chain unless the output item is stalled
   assign advance   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   fsvn_vector_lane #(.FRAC_BITS(FRAC_BITS)) u_fibre (
      .clock    (clock),
      .enable   (advance),
      .tol      (tol_ff),
      .vec_in   ('{x: req_fibre_x, y: req_fibre_y, z: req_fibre_z}),
      .vec_out  (fib_res),
      .rescaled (rsp_fibre_rescaled),
      .is_zero  (rsp_fibre_is_zero)
   );

   fsvn_vector_lane #(.FRAC_BITS(FRAC_BITS)) u_sheet (
      .clock    (clock),
      .enable   (advance),
      .tol      (tol_ff),
      .vec_in   ('{x: req_sheet_x, y: req_sheet_y, z: req_sheet_z}),
      .vec_out  (sht_res),
      .rescaled (rsp_sheet_rescaled),
      .is_zero  (rsp_sheet_is_zero)
   );

   assign rsp_fibre_x_out = fib_res.x;
   assign rsp_fibre_y_out = fib_res.y;
   assign rsp_fibre_z_out = fib_res.z;
   assign rsp_sheet_x_out = sht_res.x;
   assign rsp_sheet_y_out = sht_res.y;
   assign rsp_sheet_z_out = sht_res.z;

endmodule

### rtl/fsvn_root_cell.sv
// ----------------------------------------------------------------------------
// fsvn_root_cell: one step of the square-root chain
// Takes one result bit of floor(sqrt(S)) per cell, restoring form.
// ----------------------------------------------------------------------------
module fsvn_root_cell
   import fsvn_pkg::*;
#(
   parameter int SW   = 64,
   parameter int RW   = 32,
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [SW-1:0] rem_in_d,
   input  logic [RW-1:0] root_in_d,
   output logic [SW-1:0] rem_out_q,
   output logic [RW-1:0] root_out_q
);

   localparam int BITPOS = RW - 1 - STEP;

   logic [SW-1:0] trial;
   logic [RW-1:0] root_set;

   // test root with the next bit set against the remaining value
   always_comb begin
      root_set = root_in_d | (RW'(1) << BITPOS);
      trial    = SW'(root_set) * SW'(root_set);
   end

   // advance: keep the bit when its square fits
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_out_q  <= rem_in_d;
         root_out_q <= (trial <= rem_in_d) ? root_set : root_in_d;
      end
   end

endmodule

### rtl/fsvn_div_cell.sv
// ----------------------------------------------------------------------------
// fsvn_div_cell: one restoring division step for three numerators
// Shares the divisor across x, y and z; produces one quotient bit each.
// ----------------------------------------------------------------------------
module fsvn_div_cell
   import fsvn_pkg::*;
#(
   parameter int DW = 33,
   parameter int NW = 56
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [DW-1:0]       div_in_d,
   input  logic [3*DW-1:0]     part_in_d,
   input  logic [3*NW-1:0]     num_in_d,
   output logic [DW-1:0]       div_out_q,
   output logic [3*DW-1:0]     part_out_q,
   output logic [3*NW-1:0]     num_out_q
);

   logic [3*DW-1:0] part_next;
   logic [3*NW-1:0] num_next;
   logic [DW:0]     sh;

   // shift in the next numerator bit, subtract when it fits
   always_comb begin
      part_next = '0;
      num_next  = '0;
      sh        = '0;
      for (int k = 0; k < 3; k++) begin
         sh = {part_in_d[k*DW +: DW], num_in_d[k*NW + NW-1]};
         if (sh >= {1'b0, div_in_d}) begin
            part_next[k*DW +: DW] = DW'(sh - {1'b0, div_in_d});
            num_next[k*NW +: NW]  = {num_in_d[k*NW +: NW-1], 1'b1};
         end else begin
            part_next[k*DW +: DW] = DW'(sh);
            num_next[k*NW +: NW]  = {num_in_d[k*NW +: NW-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_out_q  <= div_in_d;
         part_out_q <= part_next;
         num_out_q  <= num_next;
      end
   end

endmodule

### rtl/fsvn_vector_lane.sv
// ----------------------------------------------------------------------------
// fsvn_vector_lane: normalize one 3D vector through a chain of cells
// Square, tolerance test, square-root cells, rounding, divider cells.
// ----------------------------------------------------------------------------
module fsvn_vector_lane
   import fsvn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [TOL_W-1:0]  tol,
   input  vec_type           vec_in,
   output vec_type           vec_out,
   output logic              rescaled,
   output logic              is_zero
);

   localparam int SW  = 2*COMP_W + 2;          // sum of three squares
   localparam int RW  = SW/2;                  // root width
   localparam int DW  = RW + 1;                // divisor and remainder width
   localparam int NW  = COMP_W + FRAC_BITS;    // numerator width
   // one +/- tolerance, wide enough for either operand
   localparam int TPW = ((TOL_W > FRAC_BITS + 2) ? TOL_W : FRAC_BITS + 2) + 1;
   localparam int THW = 2*TPW;                 // threshold square width
   localparam int CW  = (SW > THW) ? SW : THW; // tolerance compare width
   localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

   // stage 0: magnitudes and signs
   logic [COMP_W-1:0] mag_ff [3];
   logic [2:0]        neg_ff;
   vec_type           raw0_ff;
   logic [COMP_W-1:0] comp [3];

   always_comb begin
      comp[0] = vec_in.x;
      comp[1] = vec_in.y;
      comp[2] = vec_in.z;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= comp[k][COMP_W-1];
            mag_ff[k] <= comp[k][COMP_W-1] ? COMP_W'(-comp[k]) : comp[k];
         end
         raw0_ff <= vec_in;
      end
   end

   // stage 1: squares, one multiplier each
   logic [2*COMP_W-1:0] sq_ff [3];
   logic [2:0]          neg1_ff;
   vec_type             raw1_ff;
   logic [COMP_W-1:0]   mag1_ff [3];
   logic [THW-1:0]      hi_ff, lo_ff;
   logic                lo_ok_ff;
   logic [TPW-1:0]      one_p, one_m;

   always_comb begin
      one_p = TPW'(ONE) + TPW'(tol);
      one_m = TPW'(ONE) - TPW'(tol);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= (2*COMP_W)'(mag_ff[k]) * (2*COMP_W)'(mag_ff[k]);
         end
         neg1_ff  <= neg_ff;
         raw1_ff  <= raw0_ff;
         mag1_ff  <= mag_ff;
         hi_ff    <= THW'(one_p) * THW'(one_p);
         lo_ff    <= THW'(one_m) * THW'(one_m);
         lo_ok_ff <= (TPW'(tol) <= TPW'(ONE));
      end
   end

   // stage 2: sum of squares and tolerance test
   logic [SW-1:0]     s_sum;
   logic [SW-1:0]     s2_ff;
   vctl_type          ctl2_ff;
   vec_type           raw2_ff;
   logic [COMP_W-1:0] mag2_ff [3];

   always_comb begin
      s_sum = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_ff         <= s_sum;
         ctl2_ff.zero  <= (s_sum == '0);
         ctl2_ff.fix   <= (s_sum != '0) && ((CW'(s_sum) >= CW'(hi_ff)) ||
                                           (lo_ok_ff && (CW'(s_sum) <= CW'(lo_ff))));
         ctl2_ff.neg   <= neg1_ff;
         raw2_ff       <= raw1_ff;
         mag2_ff       <= mag1_ff;
      end
   end

   // square-root chain: one cell per root bit, side data rides alongside
   logic [SW-1:0]     rs [RW+1];
   logic [RW-1:0]     rr [RW+1];
   vctl_type          rctl [RW+1];
   vec_type           rraw [RW+1];
   logic [3*COMP_W-1:0] rmag [RW+1];

   assign rs[0]   = s2_ff;
   assign rr[0]   = '0;
   assign rctl[0] = ctl2_ff;
   assign rraw[0] = raw2_ff;
   assign rmag[0] = {mag2_ff[2], mag2_ff[1], mag2_ff[0]};

   for (genvar g = 0; g < RW; g++) begin : g_root
      fsvn_root_cell #(.SW(SW), .RW(RW), .STEP(g)) u_cell (
         .clock      (clock),
         .enable     (enable),
         .rem_in_d   (rs[g]),
         .root_in_d  (rr[g]),
         .rem_out_q  (rs[g+1]),
         .root_out_q (rr[g+1])
      );
      always_ff @(posedge clock) begin
         if (enable) begin
            rctl[g+1] <= rctl[g];
            rraw[g+1] <= rraw[g];
            rmag[g+1] <= rmag[g];
         end
      end
   end

   // round the root to nearest and load the divider
   logic [DW-1:0]     n_rnd;
   logic [SW-1:0]     rem_r;
   logic [DW-1:0]     dv [NW+1];
   logic [3*DW-1:0]   dp [NW+1];
   logic [3*NW-1:0]   dn [NW+1];
   vctl_type          dctl [NW+1];
   vec_type           draw [NW+1];
   logic [DW-1:0]     n_ff;
   logic [3*NW-1:0]   num_ff;
   vctl_type          ctln_ff;
   vec_type           rawn_ff;

   always_comb begin
      rem_r = rs[RW] - SW'(rr[RW]) * SW'(rr[RW]);
      n_rnd = (rem_r > SW'(rr[RW])) ? DW'(rr[RW]) + DW'(1) : DW'(rr[RW]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // zero vectors get divisor one so the chain stays defined
         n_ff <= (n_rnd == '0) ? DW'(1) : n_rnd;
         for (int k = 0; k < 3; k++) begin
            num_ff[k*NW +: NW] <= NW'(rmag[RW][k*COMP_W +: COMP_W]) << FRAC_BITS;
         end
         ctln_ff <= rctl[RW];
         rawn_ff <= rraw[RW];
      end
   end

   // divide m*2^F by n from a zero remainder; the rounding half h = n/2 is
   // folded in at the end: floor((m*2^F + h)/n) = Q + (R + h >= n), as both
   // R and h stay below n
   assign dv[0]   = n_ff;
   assign dp[0]   = '0;
   assign dn[0]   = num_ff;
   assign dctl[0] = ctln_ff;
   assign draw[0] = rawn_ff;

   for (genvar g = 0; g < NW; g++) begin : g_div
      fsvn_div_cell #(.DW(DW), .NW(NW)) u_cell (
         .clock      (clock),
         .enable     (enable),
         .div_in_d   (dv[g]),
         .part_in_d  (dp[g]),
         .num_in_d   (dn[g]),
         .div_out_q  (dv[g+1]),
         .part_out_q (dp[g+1]),
         .num_out_q  (dn[g+1])
      );
      always_ff @(posedge clock) begin
         if (enable) begin
            dctl[g+1] <= dctl[g];
            draw[g+1] <= draw[g];
         end
      end
   end

   // final step: q = Q + (R + h >= n), then sign and saturation
   vec_type  res_ff;
   logic     resc_ff, zero_ff;
   logic [NW:0]     q [3];
   logic [COMP_W-1:0] rv [3];
   logic [DW:0]     rh;

   always_comb begin
      rh = '0;
      for (int k = 0; k < 3; k++) begin
         rh   = {1'b0, dp[NW][k*DW +: DW]} + {1'b0, (dv[NW] >> 1)};
         q[k] = {1'b0, dn[NW][k*NW +: NW]} +
                (NW+1)'(rh >= {1'b0, dv[NW]});
         if (dctl[NW].neg[k]) begin
            rv[k] = (q[k] > (NW+1)'(COMP_MAXNEG)) ? COMP_MAXNEG : COMP_W'(-q[k]);
         end else begin
            rv[k] = (q[k] > (NW+1)'(COMP_MAXPOS)) ? COMP_MAXPOS : COMP_W'(q[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (dctl[NW].fix) begin
            res_ff <= '{x: rv[0], y: rv[1], z: rv[2]};
         end else begin
            res_ff <= draw[NW];
         end
         resc_ff <= dctl[NW].fix;
         zero_ff <= dctl[NW].zero;
      end
   end

   assign vec_out  = res_ff;
   assign rescaled = resc_ff;
   assign is_zero  = zero_ff;

endmodule

### rtl/fsvn_checker.sv
// ----------------------------------------------------------------------------
// fsvn_checker: port-level checks of the normalizer
// Flag consistency and handshake rules seen at the top level.
// ----------------------------------------------------------------------------
module fsvn_checker
   import fsvn_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COMP_W-1:0] rsp_fibre_x_out,
   input logic              rsp_fibre_rescaled,
   input logic              rsp_sheet_rescaled,
   input logic              rsp_fibre_is_zero,
   input logic              rsp_sheet_is_zero
);

   // a zero vector is never rescaled
   a_fibre_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fibre_rescaled && rsp_fibre_is_zero))
      else $error("fibre rescaled and zero together");

   a_sheet_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sheet_rescaled && rsp_sheet_is_zero))
      else $error("sheet rescaled and zero together");

   // input side is free whenever the output is not stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked while output free");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fibre_x_out)))
      else $error("stalled item changed");

endmodule

bind fibre_sheet_vector_normalizer fsvn_checker u_fsvn_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_fibre_x_out    (rsp_fibre_x_out),
   .rsp_fibre_rescaled (rsp_fibre_rescaled),
   .rsp_sheet_rescaled (rsp_sheet_rescaled),
   .rsp_fibre_is_zero  (rsp_fibre_is_zero),
   .rsp_sheet_is_zero  (rsp_sheet_is_zero)
);

### tb/fsvn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvn_scoreboard: result predictor and scoreboard for the vector normalizer
// Watches the register, input and result channels, works out the expected
// components and flags of each accepted item and compares them in order.
// ----------------------------------------------------------------------------
module fsvn_scoreboard
   import fsvn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [TOL_W-1:0]         csr_norm_tolerance,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [COMP_W-1:0] req_fibre_x,
   input  logic signed [COMP_W-1:0] req_fibre_y,
   input  logic signed [COMP_W-1:0] req_fibre_z,
   input  logic signed [COMP_W-1:0] req_sheet_x,
   input  logic signed [COMP_W-1:0] req_sheet_y,
   input  logic signed [COMP_W-1:0] req_sheet_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [COMP_W-1:0] rsp_fibre_x_out,
   input  logic signed [COMP_W-1:0] rsp_fibre_y_out,
   input  logic signed [COMP_W-1:0] rsp_fibre_z_out,
   input  logic signed [COMP_W-1:0] rsp_sheet_x_out,
   input  logic signed [COMP_W-1:0] rsp_sheet_y_out,
   input  logic signed [COMP_W-1:0] rsp_sheet_z_out,
   input  logic                     rsp_fibre_rescaled,
   input  logic                     rsp_sheet_rescaled,
   input  logic                     rsp_fibre_is_zero,
   input  logic                     rsp_sheet_is_zero,
   output int                       pending,
   output int                       fail_count
);

   localparam int FB = FRAC_BITS_DEF;

   typedef struct packed {
      logic [COMP_W-1:0] fx, fy, fz, sx, sy, sz;
      logic              fr, sr, fzr, szr;
   } unit_result_type;

   logic [TOL_W-1:0] tol_q;
   unit_result_type  unit_q[$];

   function automatic logic [63:0] isqrt(input logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // normalize one vector; v holds x,y,z, flags returned separately
   task automatic unitize(input logic [COMP_W-1:0] v[3], input logic [TOL_W-1:0] tol,
                          output logic [COMP_W-1:0] o[3], output logic fix,
                          output logic zero);
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] s, one, t, n, q;
      s = 0;
      one = 64'd1 << FB;
      t = 64'(tol);
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i][COMP_W-1];
         mag[i] = neg[i] ? (64'd1 << COMP_W) - v[i] : v[i];
         s = s + mag[i] * mag[i];
         o[i] = v[i];
      end
      zero = (s == 0);
      fix = 0;
      if (zero) return;
      fix = s >= (one + t) * (one + t);
      if (t <= one && s <= (one - t) * (one - t)) fix = 1;
      if (!fix) return;
      n = isqrt(s);
      if (s - n * n > n) n = n + 1;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FB) + (n >> 1)) / n;
         if (neg[i]) begin
            if (q > 64'h800000) q = 64'h800000;
            o[i] = -q[COMP_W-1:0];
         end else begin
            if (q > 64'h7FFFFF) q = 64'h7FFFFF;
            o[i] = q[COMP_W-1:0];
         end
      end
   endtask

   task automatic check_field(input string name, input logic [COMP_W-1:0] want,
                              input logic [COMP_W-1:0] got);
      if (want !== got) begin
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      logic [COMP_W-1:0] vi[3], vo[3];
      unit_result_type   e;
      if (reset) begin
         tol_q <= TOL_RESET;
         unit_q.delete();
         fail_count = 0;
      end else begin
         // track register writes
         if (csr_valid && csr_ready) tol_q <= csr_norm_tolerance;
         // predict accepted item
         if (req_valid && req_ready) begin
            vi[0] = req_fibre_x; vi[1] = req_fibre_y; vi[2] = req_fibre_z;
            unitize(vi, tol_q, vo, e.fr, e.fzr);
            e.fx = vo[0]; e.fy = vo[1]; e.fz = vo[2];
            vi[0] = req_sheet_x; vi[1] = req_sheet_y; vi[2] = req_sheet_z;
            unitize(vi, tol_q, vo, e.sr, e.szr);
            e.sx = vo[0]; e.sy = vo[1]; e.sz = vo[2];
            unit_q = {unit_q, e};
         end
         // compare result with oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (unit_q.size() == 0) begin
               $display("%0t: unexpected result item", $time);
               fail_count++;
            end else begin
               e = unit_q.pop_front();
               check_field("fibre_x", e.fx, rsp_fibre_x_out);
               check_field("fibre_y", e.fy, rsp_fibre_y_out);
               check_field("fibre_z", e.fz, rsp_fibre_z_out);
               check_field("sheet_x", e.sx, rsp_sheet_x_out);
               check_field("sheet_y", e.sy, rsp_sheet_y_out);
               check_field("sheet_z", e.sz, rsp_sheet_z_out);
               check_field("fibre_rescaled", e.fr, rsp_fibre_rescaled);
               check_field("sheet_rescaled", e.sr, rsp_sheet_rescaled);
               check_field("fibre_is_zero", e.fzr, rsp_fibre_is_zero);
               check_field("sheet_is_zero", e.szr, rsp_sheet_is_zero);
            end
         end
      end
      pending = unit_q.size();
   end

endmodule

### tb/fibre_sheet_vector_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibre_sheet_vector_normalizer_tb: stimulus and verdict for the normalizer
// Drives directed and random vector pairs under several tolerance settings
// with bursty input and a stalling receiver; the checker scores results.
// ----------------------------------------------------------------------------
module fibre_sheet_vector_normalizer_tb
   import fsvn_pkg::*;
();

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;
   localparam int ONE = 32'h100000;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [TOL_W-1:0] csr_norm_tolerance = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [COMP_W-1:0] req_fibre_x = 0, req_fibre_y = 0, req_fibre_z = 0;
   logic signed [COMP_W-1:0] req_sheet_x = 0, req_sheet_y = 0, req_sheet_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [COMP_W-1:0] rsp_fibre_x_out, rsp_fibre_y_out, rsp_fibre_z_out;
   logic signed [COMP_W-1:0] rsp_sheet_x_out, rsp_sheet_y_out, rsp_sheet_z_out;
   logic rsp_fibre_rescaled, rsp_sheet_rescaled, rsp_fibre_is_zero, rsp_sheet_is_zero;
   int   pending, fail_count;
   int   idle_cycles = 0;
   bit   hold_rsp = 0;

   always #5 clock = ~clock;

   fibre_sheet_vector_normalizer dut (.*);
   fsvn_scoreboard checker_i (.*);

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || ($time / 4000) % 3 == 0;
   end

   // watchdog on cycles without any handshake on the register, input or result side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send(input int fx, fy, fz, sx, sy, sz);
      req_valid <= 1;
      req_fibre_x <= COMP_W'(fx); req_fibre_y <= COMP_W'(fy); req_fibre_z <= COMP_W'(fz);
      req_sheet_x <= COMP_W'(sx); req_sheet_y <= COMP_W'(sy); req_sheet_z <= COMP_W'(sz);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_send();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      pause_send();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tol(input int t);
      csr_valid <= 1;
      csr_norm_tolerance <= TOL_W'(t);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // random component: near-unit values in half the draws, otherwise full range, extremes or zero
   function automatic int rand_comp();
      case ($urandom_range(0, 5))
         0: return int'($urandom);
         1: return $urandom_range(0, 1) ? 32'h7FFFFF : 32'h800000;
         2: return 0;
         default: return int'($urandom_range(0, 2 * 600000)) - 600000;
      endcase
   endfunction

   task automatic random_phase(input int count);
      int k;
      k = 0;
      while (k < count) begin
         // burst then an optional gap
         repeat ($urandom_range(1, 12)) begin
            if (k < count) begin
               send(rand_comp(), rand_comp(), rand_comp(),
                    rand_comp(), rand_comp(), rand_comp());
               k++;
            end
         end
         if ($urandom_range(0, 1)) begin
            pause_send();
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, unit vectors, zero vectors, tolerance boundary
      send(0, 0, 0, 0, 0, 0);
      send(ONE, 0, 0, 0, ONE, 0);
      send(32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h800000, 32'h800000, 32'h800000);
      send(32'h800000, 0, 0, 32'h7FFFFF, 0, 0);
      send(ONE + 10, 0, 0, ONE - 10, 0, 0);
      send(ONE + 9, 0, 0, ONE - 9, 0, 0);
      send(-ONE, 0, 0, 0, 0, -ONE);
      send(1, 0, 0, 0, 32'hFFFFFF, 0);
      send(1, 1, 1, 32'h555555, 32'hAAAAAA, 32'h123456);
      send(32'h0B504F, 32'h0B504F, 0, 32'h093CD4, 32'h093CD4, 32'h093CD4);
      drain();

      // tolerance extremes
      write_tol(0);
      send(ONE, 0, 0, 0, ONE, 0);
      send(ONE + 1, 0, 0, 0, 0, ONE - 1);
      random_phase(40);
      drain();
      write_tol(32'h100000);
      send(ONE, 0, 0, 1, 0, 0);
      send(ONE * 2, 0, 0, 0, 0, 0);
      random_phase(40);
      drain();
      write_tol(32'h1FFFFF);
      random_phase(40);
      drain();
      write_tol(32'h100001);
      random_phase(40);
      drain();

      // long receiver hold-off fills the pipeline
      write_tol(int'($urandom_range(0, 2000)));
      hold_rsp = 1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         random_phase(120);
      join
      drain();

      write_tol(int'(TOL_RESET));
      random_phase(200);
      drain();

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
